// ----- rtl/ibe_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package ibe_pkg;

    // Command codes; OP_TICK also marks the engine as idle when held as the active command.
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6
    } op_t;

    localparam logic [7:0] HOLD_RESET = 8'd5;
    localparam logic [7:0] MSB_MASK   = 8'h80;

    // Last step index of each command sequence; for a write, also the steps that end the data bits and take the ack
    localparam logic [4:0] START_LAST     = 5'd3;
    localparam logic [4:0] STOP_LAST      = 5'd2;
    localparam logic [4:0] WRITE_BITS_END = 5'd24;
    localparam logic [4:0] WRITE_SCL_ACK  = 5'd25;
    localparam logic [4:0] WRITE_ACK_STEP = 5'd26;
    localparam logic [4:0] READ_LAST      = 5'd15;
    localparam logic [4:0] ACKN_LAST      = 5'd3;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       sda_oe;
        op_t        cmd;
        logic [4:0] step;
        logic [7:0] shift;
        logic [7:0] hold;
        logic       err;
        logic [7:0] rbyte;
    } eng_state_t;

    typedef struct packed {
        logic done;
        logic rejected;
    } eng_flags_t;

endpackage

// ----- rtl/i2c_master_bit_engine.sv -----
// Top level of the I2C master bit engine: input stage, state and result registers.
`timescale 1ns / 1ps
//
// I2C master bit engine, open drain.
// Input stream (s_axis): one transfer per tick or command. tuser carries the
// operation (0 tick, 1 start, 2 stop, 3 write, 4 read, 5 ack, 6 nack, 7 ignored),
// tdata carries the write byte and the sampled SDA level.
// Output stream (m_axis): exactly one transfer per input transfer, giving the
// pin controls, busy/done flags, last read byte, ack error and command rejection.
// Config channel (cfg_*): hold_ticks, always ready; write only while idle.
// Each accepted transfer passes the input register and then the result register.
// Throughput: one transfer per cycle while m_tready is high; the engine state
// is updated from the registered input item, so items can follow back to back.
// When m_tready is low the result register holds its value and the input
// register still takes one more item; s_tready drops once both are full.
// Reset: pins released (SCL high, SDA driven high), idle, hold_ticks = 5,
// read byte and ack error cleared, both stream stages empty.
//
module i2c_master_bit_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [8] sda_in, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl_release, [1] sda_pull_low, [2] busy_res,
                                   // [3] done_res, [11:4] read_data, [12] ack_error,
                                   // [13] cmd_rejected, [15:14] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic                in_vld_reg;
    logic [2:0]          in_op_reg;
    logic [7:0]          in_wd_reg;
    logic                in_sda_reg;
    logic                out_vld_reg;
    logic [15:0]         out_data_reg;
    logic [15:0]         out_data_next;
    logic [7:0]          hold_ticks_reg;
    ibe_pkg::eng_state_t st_reg;
    ibe_pkg::eng_state_t st_next;
    ibe_pkg::eng_flags_t flags;
    logic                advance;

    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;

    ibe_step u_step
    (
        .cur        (st_reg),
        .op         (in_op_reg),
        .wdata      (in_wd_reg),
        .sda_in     (in_sda_reg),
        .hold_ticks (hold_ticks_reg),
        .nxt        (st_next),
        .flags      (flags)
    );

    assign out_data_next = {2'b00,
                            flags.rejected,
                            st_next.err,
                            st_next.rbyte,
                            flags.done,
                            (st_next.cmd != ibe_pkg::OP_TICK),
                            (st_next.sda_oe && !st_next.sda),
                            st_next.scl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            hold_ticks_reg <= ibe_pkg::HOLD_RESET;
            st_reg.scl     <= 1'b1;
            st_reg.sda     <= 1'b1;
            st_reg.sda_oe  <= 1'b1;
            st_reg.cmd     <= ibe_pkg::OP_TICK;
            st_reg.step    <= 5'd0;
            st_reg.shift   <= 8'd0;
            st_reg.hold    <= 8'd0;
            st_reg.err     <= 1'b0;
            st_reg.rbyte   <= 8'd0;
        end
        else
        begin
            if (cfg_valid) hold_ticks_reg <= cfg_data;
            if (s_tvalid && s_tready) in_vld_reg <= 1'b1;
            else if (advance)         in_vld_reg <= 1'b0;
            if (advance)
            begin
                st_reg      <= st_next;
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= s_tuser;
            in_wd_reg  <= s_tdata[7:0];
            in_sda_reg <= s_tdata[8];
        end
        if (advance) out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/ibe_step.sv -----
// Next-state logic of the bit engine for one tick or command.
`timescale 1ns / 1ps

module ibe_step
(
    input  ibe_pkg::eng_state_t cur,
    input  logic [2:0]          op,
    input  logic [7:0]          wdata,
    input  logic                sda_in,
    input  logic [7:0]          hold_ticks,
    output ibe_pkg::eng_state_t nxt,
    output ibe_pkg::eng_flags_t flags
);

    // 5-bit value mod 3: 16 and 4 are both 1 mod 3, so sum the base-4 digits
    function automatic logic [1:0] mod3(input logic [4:0] v);
        logic [2:0] s;
        logic [1:0] r;
        s = {2'b00, v[4]} + {1'b0, v[3:2]} + {1'b0, v[1:0]};
        unique case (s)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic has_next(input ibe_pkg::eng_state_t st);
        logic r;
        unique case (st.cmd)
            ibe_pkg::OP_START: r = st.step < ibe_pkg::START_LAST;
            ibe_pkg::OP_STOP:  r = st.step < ibe_pkg::STOP_LAST;
            ibe_pkg::OP_WRITE: r = (st.step < ibe_pkg::WRITE_ACK_STEP) ||
                                   (st.step == ibe_pkg::WRITE_ACK_STEP && !st.err);
            ibe_pkg::OP_READ:  r = st.step < ibe_pkg::READ_LAST;
            ibe_pkg::OP_ACK,
            ibe_pkg::OP_NACK:  r = st.step < ibe_pkg::ACKN_LAST;
            default:           r = 1'b0;
        endcase
        return r;
    endfunction

    // Pin change for the step index held in st
    function automatic ibe_pkg::eng_state_t do_step(input ibe_pkg::eng_state_t st,
                                                     input logic sda_s);
        ibe_pkg::eng_state_t r;
        logic [1:0] k;
        r = st;
        k = mod3(st.step);
        unique case (st.cmd)
            ibe_pkg::OP_START:
            begin
                if (st.step == 5'd0)
                begin
                    r.sda_oe = 1'b1;
                    r.sda    = 1'b1;
                end
                else if (st.step == 5'd1) r.scl = 1'b1;
                else if (st.step == 5'd2) r.sda = 1'b0;
                else                      r.scl = 1'b0;
            end
            ibe_pkg::OP_STOP:
            begin
                if (st.step == 5'd0)
                begin
                    r.sda_oe = 1'b1;
                    r.sda    = 1'b0;
                end
                else if (st.step == 5'd1) r.scl = 1'b1;
                else                      r.sda = 1'b1;
            end
            ibe_pkg::OP_WRITE:
            begin
                if (st.step < ibe_pkg::WRITE_BITS_END)
                begin
                    if (k == 2'd0)
                    begin
                        if (st.step == 5'd0) r.sda_oe = 1'b1;
                        r.scl = 1'b0;
                    end
                    else if (k == 2'd1)
                    begin
                        r.sda   = |(st.shift & ibe_pkg::MSB_MASK);
                        r.shift = {st.shift[6:0], 1'b0};
                    end
                    else
                    begin
                        r.scl = 1'b1;
                    end
                end
                else if (st.step == ibe_pkg::WRITE_BITS_END)
                begin
                    r.scl = 1'b0;
                end
                else if (st.step == ibe_pkg::WRITE_SCL_ACK)
                begin
                    r.sda_oe = 1'b0;
                    r.scl    = 1'b1;
                end
                else if (st.step == ibe_pkg::WRITE_ACK_STEP)
                begin
                    // released SDA here means no acknowledge
                    r.err = sda_s;
                    r.scl = 1'b0;
                    if (sda_s) r.sda_oe = 1'b1;
                end
                else
                begin
                    r.sda_oe = 1'b1;
                    r.sda    = 1'b1;
                end
            end
            ibe_pkg::OP_READ:
            begin
                if (!st.step[0])
                begin
                    if (st.step == 5'd0) r.sda_oe = 1'b0;
                    r.scl = 1'b1;
                end
                else
                begin
                    r.shift = {st.shift[6:0], sda_s};
                    r.scl   = 1'b0;
                end
            end
            ibe_pkg::OP_ACK,
            ibe_pkg::OP_NACK:
            begin
                if (st.step == 5'd0) r.scl = 1'b0;
                else if (st.step == 5'd1)
                begin
                    r.sda_oe = 1'b1;
                    r.sda    = (st.cmd == ibe_pkg::OP_NACK);
                end
                else if (st.step == 5'd2) r.scl = 1'b1;
                else                      r.scl = 1'b0;
            end
            default:
            begin
                r = st;
            end
        endcase
        return r;
    endfunction

    logic [7:0] hold_load;
    logic [7:0] hold_dec;

    assign hold_load = (hold_ticks == 8'd0) ? 8'd1 : hold_ticks;
    assign hold_dec  = (cur.hold != 8'd0) ? cur.hold - 8'd1 : 8'd0;

    always_comb
    begin
        nxt   = cur;
        flags = '0;
        if (op == ibe_pkg::OP_TICK)
        begin
            if (cur.cmd != ibe_pkg::OP_TICK)
            begin
                nxt.hold = hold_dec;
                if (hold_dec == 8'd0)
                begin
                    if (has_next(cur))
                    begin
                        nxt.step = cur.step + 5'd1;
                        nxt      = do_step(nxt, sda_in);
                        nxt.hold = hold_load;
                    end
                    else
                    begin
                        if (cur.cmd == ibe_pkg::OP_READ) nxt.rbyte = cur.shift;
                        nxt.cmd    = ibe_pkg::OP_TICK;
                        nxt.step   = 5'd0;
                        flags.done = 1'b1;
                    end
                end
            end
        end
        else if (op <= ibe_pkg::OP_NACK)
        begin
            if (cur.cmd != ibe_pkg::OP_TICK)
            begin
                flags.rejected = 1'b1;
            end
            else
            begin
                nxt.cmd   = ibe_pkg::op_t'(op);
                nxt.step  = 5'd0;
                nxt.shift = (op == ibe_pkg::OP_WRITE) ? wdata : 8'd0;
                nxt       = do_step(nxt, sda_in);
                nxt.hold  = hold_load;
            end
        end
    end

endmodule
